FILE: sv/mofg_pkg.sv
package mofg_pkg;

  localparam logic [7:0] MAX_POWER = 8'd255;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_LIMIT        = 3'd0,
    REG_RIGHT_LIMIT       = 3'd1,
    REG_MIN_POWER         = 3'd2,
    REG_FOLDBACK_STEP     = 3'd3,
    REG_RECOVERY_STEP     = 3'd4,
    REG_TRIP_SAMPLES      = 3'd5,
    REG_EMERGENCY_SAMPLES = 3'd6,
    REG_RECOVERY_SAMPLES  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_FOLDBACK = 2'd1,
    EV_TRIP     = 2'd2
  } event_t;

  typedef enum logic {
    OP_EVALUATE = 1'b0,
    OP_CLEAR    = 1'b1
  } op_t;

  typedef struct packed {
    logic [9:0] left_limit;
    logic [9:0] right_limit;
    logic [7:0] min_power;
    logic [7:0] foldback_step;
    logic [7:0] recovery_step;
    logic [7:0] trip_samples;
    logic [7:0] emergency_samples;
    logic [7:0] recovery_samples;
  } cfg_t;

  typedef struct packed {
    logic [7:0] over_count;
    logic [7:0] safe_count;
    logic [7:0] power_limit;
    logic       fault_latch;
  } state_t;

  typedef struct packed {
    logic       was_restricted;
    logic       stop_motor;
    logic       fault_active;
    logic [7:0] power_limit_now;
    event_t     event_code;
  } result_t;

endpackage

FILE: sv/mofg_core.sv
module mofg_core (
  input  mofg_pkg::cfg_t    cfg,
  input  mofg_pkg::state_t  state,
  input  mofg_pkg::op_t     operation,
  input  logic [9:0]        left_raw,
  input  logic [9:0]        right_raw,
  input  logic signed [8:0] applied_drive,
  output mofg_pkg::state_t  state_nxt,
  output mofg_pkg::result_t result
);
  import mofg_pkg::*;

  logic       over;
  logic       drive_off;
  logic [7:0] over_inc;
  logic [7:0] safe_inc;
  logic [8:0] floor_sum;
  logic [8:0] up_sum;

  assign over      = (left_raw >= cfg.left_limit) || (right_raw >= cfg.right_limit);
  assign drive_off = (applied_drive == 9'sd0);
  assign over_inc  = (state.over_count < COUNT_MAX) ? state.over_count + 8'd1
                                                    : state.over_count;
  assign safe_inc  = (state.safe_count < COUNT_MAX) ? state.safe_count + 8'd1
                                                    : state.safe_count;
  assign floor_sum = {1'b0, cfg.min_power} + {1'b0, cfg.foldback_step};
  assign up_sum    = {1'b0, state.power_limit} + {1'b0, cfg.recovery_step};

  always_comb begin
    state_nxt             = state;
    result.event_code     = EV_NONE;
    result.stop_motor     = 1'b0;
    result.was_restricted = 1'b0;
    if (operation == OP_CLEAR) begin
      result.was_restricted = state.fault_latch || (state.power_limit < MAX_POWER);
      state_nxt.over_count  = 8'd0;
      state_nxt.safe_count  = 8'd0;
      state_nxt.fault_latch = 1'b0;
      state_nxt.power_limit = MAX_POWER;
    end else if (!state.fault_latch) begin
      if (drive_off || !over) begin
        state_nxt.over_count = 8'd0;
        if (state.power_limit >= MAX_POWER) begin
          state_nxt.safe_count = 8'd0;
        end else if (safe_inc < cfg.recovery_samples) begin
          state_nxt.safe_count = safe_inc;
        end else begin
          state_nxt.safe_count  = 8'd0;
          state_nxt.power_limit = (up_sum > {1'b0, MAX_POWER}) ? MAX_POWER : up_sum[7:0];
        end
      end else begin
        state_nxt.safe_count = 8'd0;
        state_nxt.over_count = over_inc;
        if (state.power_limit > cfg.min_power) begin
          if (over_inc >= cfg.trip_samples) begin
            state_nxt.over_count  = 8'd0;
            state_nxt.power_limit = ({1'b0, state.power_limit} >= floor_sum)
                                    ? state.power_limit - cfg.foldback_step
                                    : cfg.min_power;
            result.event_code     = EV_FOLDBACK;
          end
        end else if (over_inc >= cfg.emergency_samples) begin
          state_nxt.fault_latch = 1'b1;
          result.stop_motor     = 1'b1;
          result.event_code     = EV_TRIP;
        end
      end
    end
    result.power_limit_now = state_nxt.power_limit;
    result.fault_active    = state_nxt.fault_latch;
  end

endmodule

FILE: sv/motor_overcurrent_foldback_guard.sv
// Overcurrent foldback guard for a motor drive.
// The input stream carries one request per current-sense sample: tuser holds
// the operation (evaluate or clear) and tdata the left and right raw readings
// and the signed drive now applied. Each request yields exactly one result on
// the output stream: event code, current power limit, fault latch, stop flag
// and, for a clear, whether the guard had been restricting the motor.
// A request is evaluated in the cycle it is accepted, and its result is registered
// in the output register, or in the skid register while the output is stalled.
// One request can be accepted every cycle while the skid register is empty. The
// counters and the power limit are updated in the same cycle as acceptance.
// When the receiver stalls, the result waits in the output register and one
// more result is caught in a skid register; in_tready drops only while that
// skid register is full.
// The configuration port writes one register per cycle and should be used
// only while no request is in flight.
// Synchronous reset restores the configuration registers to their defaults,
// sets the power limit to its maximum, clears counters and the fault latch,
// and empties the output stage.
module motor_overcurrent_foldback_guard (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: left_raw[9:0], right_raw[19:10], applied_drive[28:20], zero pad
  input  logic [mofg_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: operation
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata: event_code[1:0], power_limit_now[9:2], fault_active[10],
  // stop_motor[11], was_restricted[12], zero pad
  output logic [mofg_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [mofg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mofg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mofg_pkg::*;

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t result;
  result_t out_r;
  result_t skid_r;
  logic    out_vld_r;
  logic    skid_vld_r;
  logic    accept;
  logic    take;

  assign in_tready = !skid_vld_r;
  assign accept    = in_tvalid && in_tready;
  assign take      = out_vld_r && out_tready;

  mofg_core u_core (
    .cfg           (cfg_r),
    .state         (state_r),
    .operation     (op_t'(in_tuser)),
    .left_raw      (in_tdata[9:0]),
    .right_raw     (in_tdata[19:10]),
    .applied_drive (in_tdata[28:20]),
    .state_nxt     (state_nxt),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_limit        <= 10'd1023;
      cfg_r.right_limit       <= 10'd1023;
      cfg_r.min_power         <= 8'd64;
      cfg_r.foldback_step     <= 8'd32;
      cfg_r.recovery_step     <= 8'd8;
      cfg_r.trip_samples      <= 8'd3;
      cfg_r.emergency_samples <= 8'd3;
      cfg_r.recovery_samples  <= 8'd50;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEFT_LIMIT:        cfg_r.left_limit        <= cfg_data;
        REG_RIGHT_LIMIT:       cfg_r.right_limit       <= cfg_data;
        REG_MIN_POWER:         cfg_r.min_power         <= cfg_data[7:0];
        REG_FOLDBACK_STEP:     cfg_r.foldback_step     <= cfg_data[7:0];
        REG_RECOVERY_STEP:     cfg_r.recovery_step     <= cfg_data[7:0];
        REG_TRIP_SAMPLES:      cfg_r.trip_samples      <= cfg_data[7:0];
        REG_EMERGENCY_SAMPLES: cfg_r.emergency_samples <= cfg_data[7:0];
        REG_RECOVERY_SAMPLES:  cfg_r.recovery_samples  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.over_count  <= 8'd0;
      state_r.safe_count  <= 8'd0;
      state_r.power_limit <= MAX_POWER;
      state_r.fault_latch <= 1'b0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_vld_r || take) begin
        out_r     <= result;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= result;
        skid_vld_r <= 1'b1;
      end
    end else if (take) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_r.was_restricted, out_r.stop_motor, out_r.fault_active,
                       out_r.power_limit_now, out_r.event_code};

endmodule

FILE: sv/mofg_checker.sv
module mofg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mofg_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mofg_pkg::*;

  // After reset the output is empty and the guard takes requests.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("guard not idle after reset");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // A stop always comes with a trip event and a latched fault.
  a_stop_trip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[11]) |->
      (out_tdata[10] && (out_tdata[1:0] == EV_TRIP)))
    else $error("stop without trip");

  // A clear that reports a restriction leaves the guard fully restored.
  a_clear_restore: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12]) |->
      ((out_tdata[9:2] == MAX_POWER) && !out_tdata[10] && !out_tdata[11] &&
       (out_tdata[1:0] == EV_NONE)))
    else $error("clear result inconsistent");

endmodule

bind motor_overcurrent_foldback_guard mofg_checker u_mofg_checker (.*);

FILE: tb/foldback_checker.sv
module foldback_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [mofg_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [mofg_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [mofg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mofg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              results_owed,
  output logic                            guard_faulted,
  output int                              foldbacks,
  output int                              trips
);
  import mofg_pkg::*;

  localparam cfg_t RESET_REGS = '{10'd1023, 10'd1023, 8'd64, 8'd32, 8'd8, 8'd3, 8'd3, 8'd50};

  cfg_t       regs = RESET_REGS;
  logic [7:0] over_cnt = '0;
  logic [7:0] safe_cnt = '0;
  logic [7:0] limit_now = MAX_POWER;
  logic       fault_on = 1'b0;
  result_t    owed_results[$];
  result_t    want;
  result_t    got;
  logic       bad;
  int         mismatches = 0;
  int         fold_total = 0;
  int         trip_total = 0;

  function automatic result_t guard_outcome(input op_t op, input logic [9:0] l_raw,
                                            input logic [9:0] r_raw, input logic [8:0] drive);
    result_t     res;
    logic        over;
    int unsigned raised;
    int unsigned floor_sum;
    res = '0;
    res.event_code = EV_NONE;
    if (op == OP_CLEAR) begin
      res.was_restricted = fault_on || (limit_now < MAX_POWER);
      over_cnt  = '0;
      safe_cnt  = '0;
      fault_on  = 1'b0;
      limit_now = MAX_POWER;
    end else if (!fault_on) begin
      over = (l_raw >= regs.left_limit) || (r_raw >= regs.right_limit);
      if (drive == '0 || !over) begin
        over_cnt = '0;
        if (limit_now >= MAX_POWER) begin
          safe_cnt = '0;
        end else begin
          if (safe_cnt < COUNT_MAX) safe_cnt = safe_cnt + 8'd1;
          if (safe_cnt >= regs.recovery_samples) begin
            safe_cnt  = '0;
            raised    = limit_now + regs.recovery_step;
            limit_now = (raised > MAX_POWER) ? MAX_POWER : raised[7:0];
          end
        end
      end else begin
        safe_cnt = '0;
        if (over_cnt < COUNT_MAX) over_cnt = over_cnt + 8'd1;
        if (limit_now > regs.min_power) begin
          if (over_cnt >= regs.trip_samples) begin
            over_cnt  = '0;
            floor_sum = regs.min_power + regs.foldback_step;
            if (limit_now >= floor_sum) limit_now = limit_now - regs.foldback_step;
            else limit_now = regs.min_power;
            res.event_code = EV_FOLDBACK;
          end
        end else if (over_cnt >= regs.emergency_samples) begin
          fault_on       = 1'b1;
          res.stop_motor = 1'b1;
          res.event_code = EV_TRIP;
        end
      end
    end
    res.power_limit_now = limit_now;
    res.fault_active    = fault_on;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs      = RESET_REGS;
      over_cnt  = '0;
      safe_cnt  = '0;
      limit_now = MAX_POWER;
      fault_on  = 1'b0;
      owed_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_LIMIT:        regs.left_limit        = cfg_data;
          REG_RIGHT_LIMIT:       regs.right_limit       = cfg_data;
          REG_MIN_POWER:         regs.min_power         = cfg_data[7:0];
          REG_FOLDBACK_STEP:     regs.foldback_step     = cfg_data[7:0];
          REG_RECOVERY_STEP:     regs.recovery_step     = cfg_data[7:0];
          REG_TRIP_SAMPLES:      regs.trip_samples      = cfg_data[7:0];
          REG_EMERGENCY_SAMPLES: regs.emergency_samples = cfg_data[7:0];
          REG_RECOVERY_SAMPLES:  regs.recovery_samples  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = guard_outcome(op_t'(in_tuser), in_tdata[9:0], in_tdata[19:10],
                             in_tdata[28:20]);
        if (want.event_code == EV_FOLDBACK) fold_total++;
        if (want.event_code == EV_TRIP) trip_total++;
        owed_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[12:0]);
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("t=%0t: result %h arrived with no request outstanding", $time, out_tdata);
        end else begin
          want = owed_results.pop_front();
          bad  = (got.event_code != want.event_code)
              || (got.power_limit_now != want.power_limit_now)
              || (got.fault_active != want.fault_active)
              || (got.stop_motor != want.stop_motor)
              || (got.was_restricted != want.was_restricted)
              || (out_tdata[15:13] != 3'b000);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("t=%0t: mismatch, expected ev=%0d lim=%0d flt=%0b stop=%0b rstr=%0b,",
                       $time, want.event_code, want.power_limit_now, want.fault_active,
                       want.stop_motor, want.was_restricted);
              $display("  got ev=%0d lim=%0d flt=%0b stop=%0b rstr=%0b pad=%0b",
                       got.event_code, got.power_limit_now, got.fault_active,
                       got.stop_motor, got.was_restricted, out_tdata[15:13]);
            end
          end
        end
      end
    end
    fail_count    <= mismatches;
    results_owed  <= owed_results.size();
    guard_faulted <= fault_on;
    foldbacks     <= fold_total;
    trips         <= trip_total;
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import mofg_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 8;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // Request word, from bit 0 up: left_raw, right_raw, applied_drive, zero pad.
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // Operation.
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // Result word, from bit 0 up: event_code, power_limit_now, fault_active,
  // stop_motor, was_restricted, zero pad.
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int   fail_count;
  int   results_owed;
  logic guard_faulted;
  int   foldbacks;
  int   trips;

  cfg_t cur_regs = '{10'd1023, 10'd1023, 8'd64, 8'd32, 8'd8, 8'd3, 8'd3, 8'd50};
  int   burst_left    = 4;
  int   requests_sent = 0;
  int   settings_used = 1;
  int   idle_cycles   = 0;
  int   rx_mode       = 0;
  logic [5:0] rx_cycle = '0;

  motor_overcurrent_foldback_guard DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  foldback_checker guard_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .guard_faulted(guard_faulted),
    .foldbacks    (foldbacks),
    .trips        (trips)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 6'd1;
    if (rx_cycle == 6'h3f) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= (rx_cycle[1:0] != 2'd0);
      default: out_tready <= rx_cycle[3];
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("No handshake for %0d cycles, giving up.", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [8:0] any_drive();
    return 9'($urandom_range(0, 510) - 255);
  endfunction

  task automatic send_request(input op_t op, input logic [9:0] l_raw, input logic [9:0] r_raw,
                              input logic [8:0] drive);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, drive, r_raw, l_raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_regs(input cfg_t r);
    reg_idx_t idx;
    cfg_we <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      cfg_index <= idx;
      case (idx)
        REG_LEFT_LIMIT:        cfg_data <= r.left_limit;
        REG_RIGHT_LIMIT:       cfg_data <= r.right_limit;
        REG_MIN_POWER:         cfg_data <= {2'b00, r.min_power};
        REG_FOLDBACK_STEP:     cfg_data <= {2'b00, r.foldback_step};
        REG_RECOVERY_STEP:     cfg_data <= {2'b00, r.recovery_step};
        REG_TRIP_SAMPLES:      cfg_data <= {2'b00, r.trip_samples};
        REG_EMERGENCY_SAMPLES: cfg_data <= {2'b00, r.emergency_samples};
        default:               cfg_data <= {2'b00, r.recovery_samples};
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_regs = r;
    settings_used++;
  endtask

  task automatic run_traffic(input int quota);
    int         counted;
    int         pick;
    int         run_len;
    logic [9:0] l_raw;
    logic [9:0] r_raw;
    logic [8:0] drive;
    counted = 0;
    while (counted < quota) begin
      pick    = $urandom_range(0, 99);
      run_len = $urandom_range(1, 10);
      if (pick < 8 || (guard_faulted && pick < 50)) begin
        send_request(OP_CLEAR, 10'($urandom), 10'($urandom), any_drive());
        counted++;
      end else if (pick < 80) begin
        repeat (run_len) begin
          if (!guard_faulted) counted++;
          if (pick < 45) begin
            drive = 9'($urandom_range(1, 255));
            if ($urandom_range(0, 1)) drive = -drive;
            if ($urandom_range(0, 1)) begin
              l_raw = 10'($urandom_range(cur_regs.left_limit, 1023));
              r_raw = 10'($urandom);
            end else begin
              l_raw = 10'($urandom);
              r_raw = 10'($urandom_range(cur_regs.right_limit, 1023));
            end
          end else if (cur_regs.left_limit == 0 || cur_regs.right_limit == 0
                       || $urandom_range(0, 3) == 0) begin
            drive = '0;
            l_raw = 10'($urandom);
            r_raw = 10'($urandom);
          end else begin
            drive = any_drive();
            l_raw = 10'($urandom_range(0, cur_regs.left_limit - 1));
            r_raw = 10'($urandom_range(0, cur_regs.right_limit - 1));
          end
          send_request(OP_EVALUATE, l_raw, r_raw, drive);
        end
      end else begin
        if (!guard_faulted) counted++;
        send_request(($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_EVALUATE,
                     10'($urandom), 10'($urandom), any_drive());
      end
    end
  endtask

  initial begin
    cfg_t next;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: clear while unrestricted, channel extremes, one foldback.
    send_request(OP_CLEAR, 10'd0, 10'd0, 9'd0);
    send_request(OP_EVALUATE, 10'd0, 10'd0, 9'd0);
    send_request(OP_EVALUATE, 10'd1023, 10'd0, 9'd255);
    send_request(OP_EVALUATE, 10'd0, 10'd1023, -9'sd255);
    send_request(OP_EVALUATE, 10'd1023, 10'd1023, 9'd1);
    send_request(OP_EVALUATE, 10'd1023, 10'd1023, 9'd0);
    send_request(OP_EVALUATE, 10'd1022, 10'd1022, 9'h1ff);
    send_request(OP_CLEAR, 10'd1023, 10'd1023, 9'd255);
    drain_results();

    // Foldback lands on the floor, full recovery, then an emergency trip.
    load_regs('{10'd512, 10'd512, 8'd200, 8'd255, 8'd255, 8'd1, 8'd2, 8'd1});
    send_request(OP_EVALUATE, 10'd512, 10'd0, 9'h1ff);
    send_request(OP_EVALUATE, 10'd511, 10'd511, 9'd100);
    send_request(OP_EVALUATE, 10'd0, 10'd512, 9'd7);
    send_request(OP_EVALUATE, 10'd1023, 10'd1023, 9'd255);
    send_request(OP_EVALUATE, 10'd1023, 10'd1023, 9'd255);
    send_request(OP_EVALUATE, 10'd1023, 10'd1023, 9'd255);
    send_request(OP_EVALUATE, 10'd0, 10'd0, 9'd0);
    send_request(OP_CLEAR, 10'd0, 10'd0, 9'd0);
    send_request(OP_CLEAR, 10'd0, 10'd0, 9'd0);
    drain_results();

    // Zero sample counts with the floor at maximum: the first over sample trips.
    load_regs('{10'd0, 10'd1023, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_request(OP_EVALUATE, 10'd0, 10'd0, 9'd3);
    send_request(OP_CLEAR, 10'd0, 10'd0, 9'd0);
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: next = '{10'd1023, 10'd1023, 8'd64, 8'd32, 8'd8, 8'd3, 8'd3, 8'd4};
        1: next = '{10'd0, 10'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
        2: next = '{10'd700, 10'd300, 8'd0, 8'd255, 8'd1, 8'd1, 8'd1, 8'd1};
        3: next = '{10'd400, 10'd600, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        4: next = '{10'd512, 10'd512, 8'd100, 8'd50, 8'd20, 8'd2, 8'd4, 8'd3};
        default: begin
          next.left_limit        = 10'($urandom);
          next.right_limit       = 10'($urandom);
          next.min_power         = 8'($urandom);
          next.foldback_step     = 8'($urandom);
          next.recovery_step     = 8'($urandom);
          next.trip_samples      = 8'($urandom_range(1, 6));
          next.emergency_samples = 8'($urandom_range(1, 6));
          next.recovery_samples  = 8'($urandom_range(1, 6));
        end
      endcase
      load_regs(next);
      run_traffic(55);
      drain_results();
    end

    $display("Sent %0d requests across %0d register settings, bursty input and stalled output;",
             requests_sent, settings_used);
    $display("the predicted stream held %0d foldbacks and %0d trips.", foldbacks, trips);
    if (fail_count == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures, %0d results never arrived.", fail_count, results_owed);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
